// File: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// shared constants, operation codes and queue item type for the text console
// ----------------------------------------------------------------------------
package tcw_pkg;

	// default geometry
	localparam int DEF_COLUMNS     = 80;
	localparam int DEF_ROWS        = 25;
	localparam int DEF_TAB_WIDTH   = 8;
	localparam int DEF_QUEUE_DEPTH = 2;

	// field widths
	localparam int MODE_W   = 2;
	localparam int CHAR_W   = 8;
	localparam int ADDR_W   = 11;
	localparam int CURSOR_W = 11;
	localparam int CELL_W   = 16;
	localparam int ATTR_W   = 8;

	// stream data widths, fields packed from bit 0 and padded to bytes
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 32;

	// input modes
	localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

	// character codes
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

	// classified operation
	typedef enum logic [2:0] {
		OP_PUT,
		OP_BS,
		OP_TAB,
		OP_CR,
		OP_LF,
		OP_NOP,
		OP_CLEAR,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [CHAR_W-1:0] char_code;
		logic [ADDR_W-1:0] cell_address;
	} q_item_t;

endpackage

// File: rtl/text_console_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_writer_top
// character-cell text console with cursor handling, wrap, scroll and clear
// ----------------------------------------------------------------------------
// path: an accepted transaction is registered in the front stage, pushed
//   into the queue when it has room and popped by the back while idle; a
//   cell read goes through a read state, a scroll or clear through a ram
//   fill pass, and the result register loads once the output is free
// execute: one item at a time, the next taken only once the result is loaded
// reset: asynchronous, clears control state, then a clearing pass over all
//   ROWS*COLUMNS cells blanks the ram while s_axis_tready is held low
// ----------------------------------------------------------------------------
module text_console_writer_top #(
	parameter int COLUMNS   = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS      = tcw_pkg::DEF_ROWS,
	parameter int TAB_WIDTH = tcw_pkg::DEF_TAB_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration: text attribute register
	input  logic                                cfg_we,
	input  logic [tcw_pkg::ATTR_W-1:0]          cfg_wdata,
	// input stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// mode [1:0], char_code [9:2], cell_address [20:10], zero [23:21]
	input  logic [tcw_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// output stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// cursor_position [10:0], cell_data [26:11], zero [31:27]
	output logic [tcw_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int PAD_W = tcw_pkg::OUT_TDATA_W - tcw_pkg::CURSOR_W - tcw_pkg::CELL_W;

	// attribute used for written and blank cells
	logic [tcw_pkg::ATTR_W-1:0] attr_q;

	// unpacked input fields
	logic [tcw_pkg::MODE_W-1:0] in_mode;
	logic [tcw_pkg::CHAR_W-1:0] in_char;
	logic [tcw_pkg::ADDR_W-1:0] in_addr;

	// front to queue
	logic             push;
	tcw_pkg::q_item_t push_item;
	logic             q_full;

	// queue to back
	logic             pop;
	tcw_pkg::q_item_t pop_item;
	logic             q_not_empty;

	// back status, high during the clearing pass after reset
	logic             init_busy;

	// cell ram ports
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [tcw_pkg::CELL_W-1:0] ram_wdata;
	logic                       ram_re;
	logic [AW-1:0]              ram_raddr;
	logic [tcw_pkg::CELL_W-1:0] ram_rdata;

	// result fields
	logic [tcw_pkg::CURSOR_W-1:0] res_cursor;
	logic [tcw_pkg::CELL_W-1:0]   res_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::ATTR_RESET;
		end else if (cfg_we) begin
			attr_q <= cfg_wdata;
		end
	end

	assign in_mode = s_axis_tdata[1:0];
	assign in_char = s_axis_tdata[9:2];
	assign in_addr = s_axis_tdata[20:10];

	// front: accept and classify each transaction
	tcw_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.mode         (in_mode),
		.char_code    (in_char),
		.cell_address (in_addr),
		.init_busy    (init_busy),
		.q_push       (push),
		.q_item       (push_item),
		.q_full       (q_full)
	);

	// decoupling queue
	tcw_queue #(
		.DEPTH (tcw_pkg::DEF_QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.not_empty (q_not_empty)
	);

	// back: cursor logic, ram sweeps and result register
	tcw_back #(
		.COLUMNS   (COLUMNS),
		.ROWS      (ROWS),
		.TAB_WIDTH (TAB_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.attr       (attr_q),
		.q_valid    (q_not_empty),
		.q_item     (pop_item),
		.q_pop      (pop),
		.init_busy  (init_busy),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_cursor (res_cursor),
		.out_data   (res_data)
	);

	// screen cells, rows kept as a ring so that a scroll only blanks one row
	tcw_ram #(
		.WIDTH (tcw_pkg::CELL_W),
		.DEPTH (CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign m_axis_tdata = {{PAD_W{1'b0}}, res_data, res_cursor};

endmodule

// File: rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module tcw_queue #(
	parameter int DEPTH = tcw_pkg::DEF_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tcw_pkg::q_item_t push_item,
	output logic             full,
	input  logic             pop,
	output tcw_pkg::q_item_t pop_item,
	output logic             not_empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	tcw_pkg::q_item_t  entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// accepts input transactions, classifies them and feeds the queue
// ----------------------------------------------------------------------------
module tcw_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tcw_pkg::MODE_W-1:0]    mode,
	input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
	input  logic [tcw_pkg::ADDR_W-1:0]    cell_address,
	input  logic                          init_busy,
	output logic                          q_push,
	output tcw_pkg::q_item_t              q_item,
	input  logic                          q_full
);

	logic             valid_s1;
	tcw_pkg::q_item_t item_s1;
	tcw_pkg::op_t     op_class;
	logic             take;

	always_comb begin
		case (mode)
			tcw_pkg::MODE_PUT: begin
				case (char_code)
					tcw_pkg::CH_BS:  op_class = tcw_pkg::OP_BS;
					tcw_pkg::CH_TAB: op_class = tcw_pkg::OP_TAB;
					tcw_pkg::CH_CR:  op_class = tcw_pkg::OP_CR;
					tcw_pkg::CH_LF:  op_class = tcw_pkg::OP_LF;
					default: begin
						// other control bytes do nothing
						op_class = (char_code >= tcw_pkg::CH_BLANK) ?
							tcw_pkg::OP_PUT : tcw_pkg::OP_NOP;
					end
				endcase
			end
			tcw_pkg::MODE_CLEAR: op_class = tcw_pkg::OP_CLEAR;
			tcw_pkg::MODE_READ:  op_class = tcw_pkg::OP_READ;
			default:             op_class = tcw_pkg::OP_NOP;
		endcase
	end

	assign q_push   = valid_s1 && !q_full;
	assign q_item   = item_s1;
	assign in_ready = !init_busy && (!valid_s1 || !q_full);
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.op           <= op_class;
			item_s1.char_code    <= char_code;
			item_s1.cell_address <= cell_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

// File: rtl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// executes queued operations on the cell ram and cursor, owns the result
// register
// ----------------------------------------------------------------------------
module tcw_back #(
	parameter int COLUMNS   = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS      = tcw_pkg::DEF_ROWS,
	parameter int TAB_WIDTH = tcw_pkg::DEF_TAB_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [tcw_pkg::ATTR_W-1:0]     attr,
	input  logic                           q_valid,
	input  tcw_pkg::q_item_t               q_item,
	output logic                           q_pop,
	output logic                           init_busy,
	output logic                           ram_we,
	output logic [$clog2(ROWS*COLUMNS)-1:0] ram_waddr,
	output logic [tcw_pkg::CELL_W-1:0]     ram_wdata,
	output logic                           ram_re,
	output logic [$clog2(ROWS*COLUMNS)-1:0] ram_raddr,
	input  logic [tcw_pkg::CELL_W-1:0]     ram_rdata,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tcw_pkg::CURSOR_W-1:0]   out_cursor,
	output logic [tcw_pkg::CELL_W-1:0]     out_data
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int COL_W = $clog2(COLUMNS);
	localparam int ROW_W = $clog2(ROWS);
	localparam int PH_W  = $clog2(TAB_WIDTH);
	localparam int NCW   = $clog2(COLUMNS + TAB_WIDTH + 1);
	localparam int EW    = ((AW > tcw_pkg::ADDR_W) ? AW : tcw_pkg::ADDR_W) + 1;
	localparam int OW    = (AW > tcw_pkg::CURSOR_W) ? AW : tcw_pkg::CURSOR_W;

	localparam logic [AW:0]      CELLS_X   = (AW+1)'(CELLS);
	localparam logic [AW:0]      COLS_X    = (AW+1)'(COLUMNS);
	localparam logic [AW-1:0]    COLS_A    = AW'(COLUMNS);
	localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);
	localparam logic [EW-1:0]    CELLS_E   = EW'(CELLS);
	localparam logic [NCW-1:0]   COLS_N    = NCW'(COLUMNS);
	localparam logic [NCW-1:0]   TAB_N     = NCW'(TAB_WIDTH);
	localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
	localparam logic [PH_W-1:0]  PH_LAST   = PH_W'(TAB_WIDTH - 1);

	typedef enum logic [1:0] {
		ST_FILL,
		ST_IDLE,
		ST_RD,
		ST_DONE
	} state_t;

	state_t                      state_q;
	logic                        init_q;
	logic [COL_W-1:0]            col_q;
	logic [PH_W-1:0]             phase_q;
	logic [ROW_W-1:0]            row_q;
	logic [AW-1:0]               row_base_q;
	logic [AW-1:0]               top_base_q;
	logic [AW-1:0]               fill_addr_q;
	logic [AW-1:0]               fill_end_q;
	logic [tcw_pkg::ATTR_W-1:0]  blank_attr_q;
	logic [tcw_pkg::CELL_W-1:0]  data_q;
	logic                        out_valid_q;
	logic [tcw_pkg::CURSOR_W-1:0] out_cursor_q;
	logic [tcw_pkg::CELL_W-1:0]  out_data_q;

	logic [AW-1:0]  cur_pos;
	logic [AW:0]    cur_sum;
	logic [AW-1:0]  cur_phys;
	logic [EW-1:0]  rd_addr_x;
	logic [EW-1:0]  rd_sum;
	logic           rd_in_range;
	logic [AW:0]    next_top;
	logic [NCW-1:0] col_inc;
	logic [NCW-1:0] tab_col;
	logic           line_wrap;
	logic [OW-1:0]  cur_wide;
	logic           out_free;
	logic           out_load;

	// linear cursor and its place in the row ring
	assign cur_pos  = row_base_q + AW'(col_q);
	assign cur_sum  = {1'b0, cur_pos} + {1'b0, top_base_q};
	assign cur_phys = (cur_sum >= CELLS_X) ? AW'(cur_sum - CELLS_X) : AW'(cur_sum);
	assign cur_wide = OW'(cur_pos);

	assign rd_addr_x   = EW'(q_item.cell_address);
	assign rd_in_range = rd_addr_x < CELLS_E;
	assign rd_sum      = rd_addr_x + EW'(top_base_q);

	assign next_top = ({1'b0, top_base_q} + COLS_X == CELLS_X) ? '0
		: {1'b0, top_base_q} + COLS_X;

	assign col_inc = NCW'(col_q) + 1'b1;
	assign tab_col = NCW'(col_q) + TAB_N - NCW'(phase_q);

	always_comb begin
		case (q_item.op)
			tcw_pkg::OP_PUT: line_wrap = (col_inc == COLS_N);
			tcw_pkg::OP_TAB: line_wrap = (tab_col >= COLS_N);
			tcw_pkg::OP_LF:  line_wrap = 1'b1;
			default:         line_wrap = 1'b0;
		endcase
	end

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign init_busy = init_q;
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = (state_q == ST_DONE) && out_free;

	// ram ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_phys;
		ram_wdata = {attr, q_item.char_code};
		if (state_q == ST_FILL) begin
			ram_we    = 1'b1;
			ram_waddr = fill_addr_q;
			ram_wdata = {blank_attr_q, tcw_pkg::CH_BLANK};
		end else if (q_pop && (q_item.op == tcw_pkg::OP_PUT)) begin
			ram_we = 1'b1;
		end
	end

	assign ram_re    = q_pop && (q_item.op == tcw_pkg::OP_READ) && rd_in_range;
	assign ram_raddr = (rd_sum >= CELLS_E) ? AW'(rd_sum - CELLS_E) : AW'(rd_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_FILL;
			init_q       <= 1'b1;
			col_q        <= '0;
			phase_q      <= '0;
			row_q        <= '0;
			row_base_q   <= '0;
			top_base_q   <= '0;
			fill_addr_q  <= '0;
			fill_end_q   <= LAST_CELL;
			blank_attr_q <= tcw_pkg::ATTR_RESET;
			data_q       <= '0;
			out_valid_q  <= 1'b0;
			out_cursor_q <= '0;
			out_data_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_FILL: begin
					if (fill_addr_q == fill_end_q) begin
						state_q <= init_q ? ST_IDLE : ST_DONE;
						init_q  <= 1'b0;
					end else begin
						fill_addr_q <= fill_addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						data_q <= '0;
						if (line_wrap) begin
							// newline, wrap past last column, scroll at the bottom
							col_q   <= '0;
							phase_q <= '0;
							if (row_q == ROW_LAST) begin
								fill_addr_q  <= top_base_q;
								fill_end_q   <= top_base_q + COLS_A - 1'b1;
								top_base_q   <= AW'(next_top);
								blank_attr_q <= attr;
								state_q      <= ST_FILL;
							end else begin
								row_q      <= row_q + 1'b1;
								row_base_q <= row_base_q + COLS_A;
								state_q    <= ST_DONE;
							end
						end else begin
							case (q_item.op)
								tcw_pkg::OP_PUT: begin
									col_q   <= COL_W'(col_inc);
									phase_q <= (phase_q == PH_LAST) ? '0 : phase_q + 1'b1;
									state_q <= ST_DONE;
								end
								tcw_pkg::OP_BS: begin
									if (col_q != '0) begin
										col_q   <= col_q - 1'b1;
										phase_q <= (phase_q == '0) ? PH_LAST : phase_q - 1'b1;
									end
									state_q <= ST_DONE;
								end
								tcw_pkg::OP_TAB: begin
									col_q   <= COL_W'(tab_col);
									phase_q <= '0;
									state_q <= ST_DONE;
								end
								tcw_pkg::OP_CR: begin
									col_q   <= '0;
									phase_q <= '0;
									state_q <= ST_DONE;
								end
								tcw_pkg::OP_CLEAR: begin
									col_q        <= '0;
									phase_q      <= '0;
									row_q        <= '0;
									row_base_q   <= '0;
									top_base_q   <= '0;
									fill_addr_q  <= '0;
									fill_end_q   <= LAST_CELL;
									blank_attr_q <= attr;
									state_q      <= ST_FILL;
								end
								tcw_pkg::OP_READ: begin
									state_q <= rd_in_range ? ST_RD : ST_DONE;
								end
								default: begin
									state_q <= ST_DONE;
								end
							endcase
						end
					end
				end
				ST_RD: begin
					data_q  <= ram_rdata;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						out_cursor_q <= cur_wide[tcw_pkg::CURSOR_W-1:0];
						out_data_q   <= data_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_cursor = out_cursor_q;
	assign out_data   = out_data_q;

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(col_q) < COLUMNS)
		else $error("cursor column out of range");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(row_q) < ROWS)
		else $error("cursor row out of range");

	a_row_base: assert property (@(posedge clk) disable iff (!arst_n)
		int'(row_base_q) == int'(row_q) * COLUMNS)
		else $error("row base out of step with cursor row");

	a_top_base: assert property (@(posedge clk) disable iff (!arst_n)
		int'(top_base_q) < CELLS)
		else $error("ring top row base out of range");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !q_pop)
		else $error("item taken during reset clearing pass");

endmodule
